// ===== rtl/core/bfp_pkg.sv =====
// Shared types, constants and SHA-512 helper functions for the Bloom filter probe core.
package bfp_pkg;

  localparam int FilterBitsDefault = 20;
  localparam int ProbesDefault = 8;
  localparam int StoreAw = 17;
  localparam int HashBits = 512;
  localparam int Rounds = 80;

  localparam logic [1:0] StatusWritten = 2'd0;
  localparam logic [1:0] StatusAbsent = 2'd1;
  localparam logic [1:0] StatusMaybe = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ROUND,
    ST_FINAL,
    ST_READ,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic store_wr;
    logic round;
    logic finish;
    logic probe_read;
    logic probe_next;
  } cmd_t;

  typedef struct packed {
    logic rounds_done;
    logic probes_done;
    logic bit_clear;
  } stat_t;

  function automatic logic [63:0] round_const(input logic [6:0] i);
    logic [63:0] k;
    case (i)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  localparam logic [511:0] Iv = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

endpackage

// ===== rtl/core/bfp_ctrl.sv =====
// Controller state machine sequencing writes, hash rounds and filter probes.
module bfp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output bfp_pkg::cmd_t ctl,
  input  bfp_pkg::stat_t st
);

  bfp_pkg::state_t state, state_next;
  logic [1:0] status_next;

  always_comb begin
    state_next = state;
    case (state)
      bfp_pkg::ST_IDLE: begin
        if (in_valid) state_next = cmd ? bfp_pkg::ST_ROUND : bfp_pkg::ST_WRITE;
      end
      bfp_pkg::ST_WRITE: state_next = bfp_pkg::ST_DONE;
      bfp_pkg::ST_ROUND: begin
        if (st.rounds_done) state_next = bfp_pkg::ST_FINAL;
      end
      bfp_pkg::ST_FINAL: state_next = bfp_pkg::ST_READ;
      bfp_pkg::ST_READ: state_next = bfp_pkg::ST_TEST;
      bfp_pkg::ST_TEST: begin
        if (st.bit_clear || st.probes_done) state_next = bfp_pkg::ST_DONE;
        else state_next = bfp_pkg::ST_READ;
      end
      bfp_pkg::ST_DONE: begin
        if (out_ready) state_next = bfp_pkg::ST_IDLE;
      end
      default: state_next = bfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    status_next = status;
    case (state)
      bfp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      bfp_pkg::ST_WRITE: begin
        ctl.store_wr = 1'b1;
        status_next = bfp_pkg::StatusWritten;
      end
      bfp_pkg::ST_ROUND: ctl.round = 1'b1;
      bfp_pkg::ST_FINAL: ctl.finish = 1'b1;
      bfp_pkg::ST_READ: ctl.probe_read = 1'b1;
      bfp_pkg::ST_TEST: begin
        ctl.probe_next = 1'b1;
        if (st.bit_clear) status_next = bfp_pkg::StatusAbsent;
        else if (st.probes_done) status_next = bfp_pkg::StatusMaybe;
      end
      bfp_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfp_pkg::ST_IDLE;
      status <= bfp_pkg::StatusWritten;
    end else begin
      state <= state_next;
      status <= status_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_done_after_test: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bfp_pkg::ST_TEST || $past(state) == bfp_pkg::ST_WRITE)
    else $error("result without work");
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");

endmodule

// ===== rtl/core/bfp_datapath.sv =====
// Datapath: SHA-512 round unit, message schedule, probe slicer and filter store.
module bfp_datapath #(
  parameter int FILTER_BITS = bfp_pkg::FilterBitsDefault,
  parameter int PROBES = bfp_pkg::ProbesDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    digest_head,
  input  logic [63:0]    digest_middle,
  input  logic [31:0]    digest_tail,
  input  logic [16:0]    store_address,
  input  logic [7:0]     store_byte,
  input  bfp_pkg::cmd_t  ctl,
  output bfp_pkg::stat_t st
);

  localparam int PW = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int SW = (FILTER_BITS > 17 + 3) ? 20 : FILTER_BITS;

  logic [7:0] mem [0:(1 << bfp_pkg::StoreAw) - 1];
  logic [16:0] wr_addr;
  logic [7:0] wr_byte, rd_byte;
  logic [63:0] w [0:15];
  logic [63:0] a, b, c, d, e, f, g, hh;
  logic [6:0] rnd;
  logic [511:0] hash;
  logic [PW-1:0] probe;
  logic [2:0] bit_sel;

  logic [63:0] s0, s1, wn, t1, t2, s_e, s_a, ch, mj;
  logic [SW-1:0] slice;
  logic [31:0] base;
  logic [16:0] rd_addr;

  always_comb begin
    s0 = {w[1][0], w[1][63:1]} ^ {w[1][7:0], w[1][63:8]} ^ (w[1] >> 7);
    s1 = {w[14][18:0], w[14][63:19]} ^ {w[14][60:0], w[14][63:61]} ^ (w[14] >> 6);
    wn = w[0] + s0 + w[9] + s1;
    s_e = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    ch = (e & f) ^ (~e & g);
    t1 = hh + s_e + ch + bfp_pkg::round_const(rnd) + w[0];
    s_a = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    mj = (a & b) ^ (a & c) ^ (b & c);
    t2 = s_a + mj;
    base = 32'(probe) * 32'(FILTER_BITS);
    for (int i = 0; i < SW; i++) begin
      if (base + 32'(i) < 32'(bfp_pkg::HashBits))
        slice[i] = hash[9'(base + 32'(i))];
      else
        slice[i] = 1'b0;
    end
    rd_addr = 17'(32'(slice) >> 3);
  end

  // hash holds the result as a little-endian byte string, byte 0 in bits 7:0
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      w[0] <= digest_head;
      w[1] <= digest_middle;
      w[2] <= {digest_tail, 32'h80000000};
      for (int i = 3; i < 15; i++) w[i] <= '0;
      w[15] <= 64'd160;
      {a, b, c, d, e, f, g, hh} <= bfp_pkg::Iv;
      wr_addr <= store_address;
      wr_byte <= store_byte;
    end else if (ctl.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      hh <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
    if (ctl.finish) begin
      logic [511:0] sum;
      sum = {a + bfp_pkg::Iv[511:448], b + bfp_pkg::Iv[447:384],
             c + bfp_pkg::Iv[383:320], d + bfp_pkg::Iv[319:256],
             e + bfp_pkg::Iv[255:192], f + bfp_pkg::Iv[191:128],
             g + bfp_pkg::Iv[127:64], hh + bfp_pkg::Iv[63:0]};
      for (int k = 0; k < 64; k++) hash[k*8 +: 8] <= sum[511 - k*8 -: 8];
    end
    if (ctl.probe_read) bit_sel <= slice[2:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.store_wr) mem[wr_addr] <= wr_byte;
    if (ctl.probe_read) rd_byte <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load) begin
      rnd <= '0;
      probe <= '0;
    end else begin
      if (ctl.round) rnd <= rnd + 7'd1;
      if (ctl.probe_next) probe <= probe + PW'(1);
    end
  end

  assign st.rounds_done = (rnd == 7'(bfp_pkg::Rounds - 1));
  assign st.probes_done = (32'(probe) == 32'(PROBES - 1));
  assign st.bit_clear = ~rd_byte[bit_sel];

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.round |-> rnd < 7'(bfp_pkg::Rounds)) else $error("round overrun");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.probe_next |-> 32'(probe) < 32'(PROBES)) else $error("probe overrun");
  a_finish_after_rounds: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> $past(ctl.round) && $past(st.rounds_done)) else $error("early finish");

endmodule

// ===== rtl/core/bloom_filter_probe_sha512_core.sv =====
// Top level of the Bloom filter probe keyed by SHA-512 of a SHA-1 digest.
// Input channel in_valid/in_ready carries one item: cmd selects a filter byte
// write (store_address, store_byte) or a query (digest_head/middle/tail).
// Output channel out_valid/out_ready returns one status per item:
// written, not in filter, or maybe in filter.
// A write stores its byte in the write state, then returns its result. A query runs the 80
// SHA-512 rounds on one shared round unit, one round a cycle, then the
// final addition, then a read state and a test state per probe for the filter
// store read port; it ends early when a probe finds a clear bit.
// One item is in flight at a time; the next is accepted the cycle after
// the result is taken. The filter store is not cleared at reset; software
// writes every byte before the first query. Reset returns the controller
// to idle. While out_ready is low the result holds and no item is taken.
module bloom_filter_probe_sha512_core #(
  parameter int FILTER_BITS = bfp_pkg::FilterBitsDefault,
  parameter int PROBES = bfp_pkg::ProbesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] digest_head,
  input  logic [63:0] digest_middle,
  input  logic [31:0] digest_tail,
  input  logic [16:0] store_address,
  input  logic [7:0]  store_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status
);

  bfp_pkg::cmd_t ctl;
  bfp_pkg::stat_t st;

  bfp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .ctl(ctl), .st(st)
  );

  bfp_datapath #(.FILTER_BITS(FILTER_BITS), .PROBES(PROBES)) u_dp (
    .clk(clk), .rst(rst), .digest_head(digest_head), .digest_middle(digest_middle),
    .digest_tail(digest_tail), .store_address(store_address), .store_byte(store_byte),
    .ctl(ctl), .st(st)
  );

endmodule

// ===== tb/sv/bloom_filter_probe_sha512_core_test.sv =====
// Testbench for the Bloom filter probe core: filter byte writes and SHA-512 keyed queries.
`timescale 1ns / 1ps

module bloom_filter_probe_sha512_core_test;

  localparam int FltBits = bfp_pkg::FilterBitsDefault;
  localparam int NumProbes = bfp_pkg::ProbesDefault;
  localparam int StoreDepth = 1 << bfp_pkg::StoreAw;
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam int CycleLimit = 3000000;

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef struct packed {
    logic        cmd;
    logic [63:0] head;
    logic [63:0] middle;
    logic [31:0] tail;
    logic [16:0] addr;
    logic [7:0]  value;
  } probe_item_t;

  typedef struct packed {
    probe_item_t item;
    logic        typed;
    logic [1:0]  status;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [63:0] digest_head = '0;
  logic [63:0] digest_middle = '0;
  logic [31:0] digest_tail = '0;
  logic [16:0] store_address = '0;
  logic [7:0]  store_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;

  logic [7:0]  filter_bytes [StoreDepth];
  bit          byte_loaded [StoreDepth];
  logic [1:0]  status_due [$];
  logic [159:0] past_digests [$];
  logic [16:0] probed_addrs [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  longint      cycles = 0;

  bloom_filter_probe_sha512_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .digest_head(digest_head), .digest_middle(digest_middle), .digest_tail(digest_tail),
    .store_address(store_address), .store_byte(store_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [511:0] sha512_of_digest(input logic [159:0] msg);
    logic [63:0] w [80];
    logic [63:0] a, b, c, d, e, f, g, hh, t1, t2;
    logic [511:0] hv;
    for (int i = 0; i < 16; i++) w[i] = '0;
    w[0] = msg[159:96];
    w[1] = msg[95:32];
    w[2] = {msg[31:0], 32'h8000_0000};
    w[15] = 64'd160;
    for (int i = 16; i < 80; i++) begin
      w[i] = w[i-16] + (rotr64(w[i-15], 1) ^ rotr64(w[i-15], 8) ^ (w[i-15] >> 7))
           + w[i-7] + (rotr64(w[i-2], 19) ^ rotr64(w[i-2], 61) ^ (w[i-2] >> 6));
    end
    {a, b, c, d, e, f, g, hh} = bfp_pkg::Iv;
    for (int i = 0; i < 80; i++) begin
      t1 = hh + (rotr64(e, 14) ^ rotr64(e, 18) ^ rotr64(e, 41)) + ((e & f) ^ (~e & g))
         + RoundK[i] + w[i];
      t2 = (rotr64(a, 28) ^ rotr64(a, 34) ^ rotr64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hv = {a, b, c, d, e, f, g, hh};
    for (int i = 0; i < 8; i++)
      hv[511 - 64*i -: 64] = hv[511 - 64*i -: 64] + bfp_pkg::Iv[511 - 64*i -: 64];
    return hv;
  endfunction

  function automatic logic little_endian_bit(input logic [511:0] hv, input int n);
    int wd, pos;
    if (n >= bfp_pkg::HashBits) return 1'b0;
    wd = n >> 6;
    pos = 56 - 8 * ((n & 63) >> 3) + (n & 7);
    return hv[448 - 64*wd + pos];
  endfunction

  function automatic void probe_location(input logic [511:0] hv, input int p,
                                         output logic [16:0] addr, output logic [2:0] bpos);
    logic [63:0] slice;
    slice = '0;
    for (int b = 0; b < FltBits && b < 64; b++) slice[b] = little_endian_bit(hv, p * FltBits + b);
    addr = slice[19:3];
    bpos = slice[2:0];
  endfunction

  function automatic logic [1:0] filter_status(input probe_item_t it);
    logic [511:0] hv;
    logic [16:0] addr;
    logic [2:0] bpos;
    if (it.cmd == CmdWrite) begin
      filter_bytes[it.addr] = it.value;
      byte_loaded[it.addr] = 1'b1;
      return bfp_pkg::StatusWritten;
    end
    hv = sha512_of_digest({it.head, it.middle, it.tail});
    for (int p = 0; p < NumProbes; p++) begin
      probe_location(hv, p, addr, bpos);
      if (!filter_bytes[addr][bpos]) return bfp_pkg::StatusAbsent;
    end
    return bfp_pkg::StatusMaybe;
  endfunction

  task automatic report_mismatch(input string what, input logic [1:0] want, input logic [1:0] got);
    $display("mismatch at cycle %0d: %s, expected %0d, got %0d", cycles, what, want, got);
    errors++;
  endtask

  task automatic send_item(input probe_item_t it, input logic typed, input logic [1:0] want);
    int gap;
    logic [1:0] st;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    digest_head <= it.head;
    digest_middle <= it.middle;
    digest_tail <= it.tail;
    store_address <= it.addr;
    store_byte <= it.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = filter_status(it);
    status_due.push_back(typed ? want : st);
  endtask

  // load every filter byte this query will read, mostly with the probed bit set
  task automatic send_query(input probe_item_t it, input logic typed, input logic [1:0] want);
    logic [511:0] hv;
    logic [16:0] addr;
    logic [2:0] bpos;
    probe_item_t wr;
    hv = sha512_of_digest({it.head, it.middle, it.tail});
    for (int p = 0; p < NumProbes; p++) begin
      probe_location(hv, p, addr, bpos);
      if (!byte_loaded[addr]) begin
        wr = {CmdWrite, 64'($urandom) << 32 | 64'($urandom), {$urandom, $urandom},
              32'($urandom), addr, 8'($urandom)};
        wr.value[bpos] = ($urandom_range(99) < 88);
        send_item(wr, 1'b0, bfp_pkg::StatusWritten);
      end
      if (probed_addrs.size() < 256) probed_addrs.push_back(addr);
      if (!filter_bytes[addr][bpos]) break;
    end
    if (past_digests.size() < 64) past_digests.push_back({it.head, it.middle, it.tail});
    send_item(it, typed, want);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
  endtask

  function automatic probe_item_t random_item(input logic c);
    probe_item_t it;
    it = {c, {$urandom, $urandom}, {$urandom, $urandom}, 32'($urandom),
          17'($urandom), 8'($urandom)};
    return it;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) report_mismatch("result with nothing due", 2'd3, status);
        else if (status !== status_due[0]) report_mismatch("status", status_due.pop_front(), status);
        else void'(status_due.pop_front());
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    table_row_t rows [$];
    probe_item_t it;
    int r;
    int waited;
    rows.push_back({{CmdWrite, 64'h0, 64'h0, 32'h0, 17'h00000, 8'h00}, 1'b1,
                     bfp_pkg::StatusWritten});
    rows.push_back({{CmdWrite, 64'hffffffffffffffff, 64'hffffffffffffffff, 32'hffffffff,
                     17'h1ffff, 8'hff}, 1'b1, bfp_pkg::StatusWritten});
    rows.push_back({{CmdWrite, 64'h0, 64'h0, 32'h0, 17'h0aaaa, 8'h55}, 1'b1,
                     bfp_pkg::StatusWritten});
    rows.push_back({{CmdWrite, 64'h0, 64'h0, 32'h0, 17'h15555, 8'haa}, 1'b1,
                     bfp_pkg::StatusWritten});
    rows.push_back({{CmdQuery, 64'h0, 64'h0, 32'h0, 17'h0, 8'h0}, 1'b0,
                     bfp_pkg::StatusWritten});
    rows.push_back({{CmdQuery, 64'hffffffffffffffff, 64'hffffffffffffffff, 32'hffffffff,
                     17'h1ffff, 8'hff}, 1'b0, bfp_pkg::StatusWritten});
    rows.push_back({{CmdQuery, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 32'haaaaaaaa,
                     17'h0, 8'h0}, 1'b0, bfp_pkg::StatusWritten});
    rows.push_back({{CmdQuery, 64'h0123456789abcdef, 64'hfedcba9876543210, 32'hdeadbeef,
                     17'h15555, 8'h5a}, 1'b0, bfp_pkg::StatusWritten});
    rows.push_back({{CmdQuery, 64'h8000000000000000, 64'h0, 32'h1, 17'h0, 8'h0}, 1'b0,
                     bfp_pkg::StatusWritten});
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].item.cmd == CmdQuery) send_query(rows[i].item, rows[i].typed, rows[i].status);
      else send_item(rows[i].item, rows[i].typed, rows[i].status);
    end
    // hold off until every result is back
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < 85; n++) begin
        r = $urandom_range(99);
        if (r < 55 || past_digests.size() == 0) begin
          send_query(random_item(CmdQuery), 1'b0, bfp_pkg::StatusWritten);
        end else if (r < 70) begin
          it = random_item(CmdQuery);
          {it.head, it.middle, it.tail} = past_digests[$urandom_range(past_digests.size() - 1)];
          send_query(it, 1'b0, bfp_pkg::StatusWritten);
        end else if (r < 85 && probed_addrs.size() != 0) begin
          it = random_item(CmdWrite);
          it.addr = probed_addrs[$urandom_range(probed_addrs.size() - 1)];
          if ($urandom_range(1)) it.value = '1;
          send_item(it, 1'b0, bfp_pkg::StatusWritten);
        end else begin
          send_item(random_item(CmdWrite), 1'b0, bfp_pkg::StatusWritten);
        end
      end
      drain();
    end
    waited = 0;
    while (status_due.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (120) @(posedge clk);
    if (errors == 0 && status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bfp_pkg.sv
rtl/core/bfp_ctrl.sv
rtl/core/bfp_datapath.sv
rtl/core/bloom_filter_probe_sha512_core.sv
tb/sv/bloom_filter_probe_sha512_core_test.sv
